FILE: src/pmad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmad_pkg
// Types and constants shared by the physical memory access decoder: request
// and response payloads, operation, size and status codes, register indexes.
// ----------------------------------------------------------------------------
package pmad_pkg;

	// operation codes
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_STORE = 2'd1,
		OP_FILL  = 2'd2
	} op_t;

	// access size codes
	typedef enum logic [1:0] {
		SZ_BYTE = 2'd0,
		SZ_HALF = 2'd1,
		SZ_WORD = 2'd2
	} size_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_MISALIGN = 2'd1,
		ST_FAULT    = 2'd2,
		ST_IO       = 2'd3
	} status_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAM_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_BASE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IO_BASE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IO_WIN_SIZE = 2'd3;

	// configuration widths and reset values
	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned IO_SIZE_W = 29;
	localparam int unsigned IO_OFF_W  = 28;

	localparam logic [ADDR_W-1:0]    DRAM_BASE_RST   = 32'h2000_0000;
	localparam logic [ADDR_W-1:0]    ROM_BASE_RST    = 32'h0001_0000;
	localparam logic [ADDR_W-1:0]    IO_BASE_RST     = 32'h0400_0000;
	localparam logic [IO_SIZE_W-1:0] IO_WIN_SIZE_RST = 29'h0200_0000;
	localparam logic [IO_SIZE_W-1:0] IO_SIZE_MAX     = 29'h1000_0000;

	// request payload
	typedef struct packed {
		logic [1:0]        operation;
		logic [1:0]        access_size;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
	} req_t;

	// response payload
	typedef struct packed {
		status_t             status;
		logic [DATA_W-1:0]   read_data;
		logic [IO_OFF_W-1:0] io_window_off;
		logic                io_is_write;
	} rsp_t;

	// byte lanes touched by an access at lane offset zero
	function automatic logic [3:0] lane_bytes(input logic [1:0] size);
		logic [3:0] b;
		begin
			unique case (size)
				SZ_BYTE: b = 4'b0001;
				SZ_HALF: b = 4'b0011;
				default: b = 4'b1111;
			endcase
			return b;
		end
	endfunction

	// bit mask of a zero-extended load result
	function automatic logic [DATA_W-1:0] lane_mask(input logic [1:0] size);
		logic [DATA_W-1:0] m;
		begin
			unique case (size)
				SZ_BYTE: m = 32'h0000_00FF;
				SZ_HALF: m = 32'h0000_FFFF;
				default: m = 32'hFFFF_FFFF;
			endcase
			return m;
		end
	endfunction

endpackage
`default_nettype wire

FILE: src/physical_memory_access_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// physical_memory_access_decoder
// Decodes one physical access against the DRAM, boot ROM and IO windows,
// performs DRAM and ROM reads and writes, and reports status per access.
// ----------------------------------------------------------------------------
//  channel   ports                          direction  transfer when
//  request   start, busy, req               in         start && !busy
//  response  done, rsp                      out        done (one cycle strobe)
//  config    cfg_we, cfg_index, cfg_wdata   in         cfg_we
//
// One access is taken per cycle while busy is low; each response passes the
// input register, decode with memory access, and the result register.
// After reset the boot ROM is cleared one word per cycle, from the first word
// to the last; busy is high meanwhile.
// Configuration writes are taken at any time, including during the clear.
// The receiver cannot stall: every response is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module physical_memory_access_decoder #(
	parameter int DRAM_BYTES_LOG2 = 16,
	parameter int ROM_BYTES_LOG2  = 12
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire pmad_pkg::req_t                    req,
	output logic                                   done,
	output pmad_pkg::rsp_t                         rsp,
	input  wire logic                              cfg_we,
	input  wire logic [pmad_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pmad_pkg::DATA_W-1:0]       cfg_wdata
);

	import pmad_pkg::*;

	localparam int DA         = DRAM_BYTES_LOG2 - 2;
	localparam int RA         = ROM_BYTES_LOG2 - 2;
	localparam int DRAM_DEPTH = 2 ** DA;
	localparam int ROM_DEPTH  = 2 ** RA;

	// configuration registers
	logic [ADDR_W-1:0]    dram_base_q;
	logic [ADDR_W-1:0]    rom_base_q;
	logic [ADDR_W-1:0]    io_base_q;
	logic [IO_SIZE_W-1:0] io_win_size_q;

	// rom clear sweep
	logic          clearing_q;
	logic [RA-1:0] clr_idx_q;

	// stage 1: input register
	logic valid_s1;
	req_t req_s1;

	// stage 1 decode
	status_t             status_d;
	logic                rd_dram_d;
	logic                rd_rom_d;
	logic [1:0]          lane_d;
	logic [IO_OFF_W-1:0] io_off_d;
	logic                io_wr_d;
	logic [ADDR_W-1:0]   doff;
	logic [ADDR_W-1:0]   roff;
	logic [ADDR_W-1:0]   ioff;
	logic [IO_SIZE_W-1:0] io_size_c;
	logic                dram_hit;
	logic                rom_hit;
	logic                io_hit;
	logic                misalign;

	// memory ports
	logic              dram_we;
	logic [3:0]        dram_be;
	logic [DATA_W-1:0] dram_wdata;
	logic [DATA_W-1:0] dram_rdata;
	logic              rom_we;
	logic [RA-1:0]     rom_waddr;
	logic [DATA_W-1:0] rom_wdata;
	logic [DATA_W-1:0] rom_rdata;

	// stage 2: decoded controls, memory read data arrives alongside
	logic                valid_s2;
	status_t             status_s2;
	logic                rd_dram_s2;
	logic                rd_rom_s2;
	logic [1:0]          lane_s2;
	logic [1:0]          size_s2;
	logic [IO_OFF_W-1:0] io_off_s2;
	logic                io_wr_s2;

	// result register
	logic              done_q;
	rsp_t              rsp_q;
	logic [DATA_W-1:0] rdata_c;
	logic [DATA_W-1:0] word_c;

	logic accept;

	assign busy   = clearing_q;
	assign accept = start && !busy;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dram_base_q   <= DRAM_BASE_RST;
			rom_base_q    <= ROM_BASE_RST;
			io_base_q     <= IO_BASE_RST;
			io_win_size_q <= IO_WIN_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DRAM_BASE:   dram_base_q   <= cfg_wdata;
				CFG_ROM_BASE:    rom_base_q    <= cfg_wdata;
				CFG_IO_BASE:     io_base_q     <= cfg_wdata;
				CFG_IO_WIN_SIZE: io_win_size_q <= cfg_wdata[IO_SIZE_W-1:0];
			endcase
		end
	end

	// rom clear sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == {RA{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// window offsets and hits
	assign doff      = req_s1.address - dram_base_q;
	assign roff      = req_s1.address - rom_base_q;
	assign ioff      = req_s1.address - io_base_q;
	assign io_size_c = (io_win_size_q > IO_SIZE_MAX) ? IO_SIZE_MAX : io_win_size_q;
	assign dram_hit  = (doff[ADDR_W-1:DRAM_BYTES_LOG2] == '0);
	assign rom_hit   = (roff[ADDR_W-1:ROM_BYTES_LOG2] == '0);
	assign io_hit    = (ioff < {{(ADDR_W-IO_SIZE_W){1'b0}}, io_size_c});
	assign misalign  = ((req_s1.access_size == SZ_WORD) && (req_s1.address[1:0] != 2'b00))
		|| ((req_s1.access_size == SZ_HALF) && req_s1.address[0]);

	// access decode, in priority order
	always_comb begin
		status_d  = ST_FAULT;
		rd_dram_d = 1'b0;
		rd_rom_d  = 1'b0;
		lane_d    = doff[1:0];
		io_off_d  = '0;
		io_wr_d   = 1'b0;
		dram_we   = 1'b0;
		rom_we    = 1'b0;
		if (req_s1.operation == OP_FILL) begin
			if (req_s1.address[1:0] != 2'b00) begin
				status_d = ST_MISALIGN;
			end else if (req_s1.address[ADDR_W-1:ROM_BYTES_LOG2] == '0) begin
				status_d = ST_DONE;
				rom_we   = valid_s1;
			end
		end else if ((req_s1.operation == OP_LOAD || req_s1.operation == OP_STORE)
			&& (req_s1.access_size == SZ_BYTE || req_s1.access_size == SZ_HALF
			|| req_s1.access_size == SZ_WORD)) begin
			priority if (misalign) begin
				status_d = ST_MISALIGN;
			end else if (dram_hit) begin
				status_d  = ST_DONE;
				rd_dram_d = (req_s1.operation == OP_LOAD);
				dram_we   = valid_s1 && (req_s1.operation == OP_STORE);
			end else if (req_s1.operation == OP_LOAD && rom_hit) begin
				status_d = ST_DONE;
				rd_rom_d = 1'b1;
				lane_d   = roff[1:0];
			end else if (req_s1.access_size == SZ_WORD && io_hit) begin
				status_d = ST_IO;
				io_off_d = ioff[IO_OFF_W-1:0];
				io_wr_d  = (req_s1.operation == OP_STORE);
			end else begin
				status_d = ST_FAULT;
			end
		end
	end

	// dram store lanes, little-endian
	assign dram_be    = 4'(lane_bytes(req_s1.access_size) << doff[1:0]);
	assign dram_wdata = req_s1.write_data << {doff[1:0], 3'b000};

	// rom write port: clear sweep or fill word
	assign rom_waddr = clearing_q ? clr_idx_q : req_s1.address[ROM_BYTES_LOG2-1:2];
	assign rom_wdata = clearing_q ? '0 : req_s1.write_data;

	pmad_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DRAM_DEPTH)
	) u_dram (
		.clk  (clk),
		.we   (dram_we),
		.be   (dram_be),
		.waddr(doff[DRAM_BYTES_LOG2-1:2]),
		.wdata(dram_wdata),
		.raddr(doff[DRAM_BYTES_LOG2-1:2]),
		.rdata(dram_rdata)
	);

	pmad_ram #(
		.WIDTH(DATA_W),
		.DEPTH(ROM_DEPTH)
	) u_rom (
		.clk  (clk),
		.we   (clearing_q || rom_we),
		.be   (4'b1111),
		.waddr(rom_waddr),
		.wdata(rom_wdata),
		.raddr(roff[ROM_BYTES_LOG2-1:2]),
		.rdata(rom_rdata)
	);

	// decode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		status_s2  <= status_d;
		rd_dram_s2 <= rd_dram_d;
		rd_rom_s2  <= rd_rom_d;
		lane_s2    <= lane_d;
		size_s2    <= req_s1.access_size;
		io_off_s2  <= io_off_d;
		io_wr_s2   <= io_wr_d;
	end

	// load lane select and zero extension
	assign word_c  = rd_dram_s2 ? dram_rdata : rom_rdata;
	assign rdata_c = (rd_dram_s2 || rd_rom_s2)
		? ((word_c >> {lane_s2, 3'b000}) & lane_mask(size_s2)) : '0;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q.status        <= status_s2;
		rsp_q.read_data     <= rdata_c;
		rsp_q.io_window_off <= io_off_s2;
		rsp_q.io_is_write   <= io_wr_s2;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// no response can come out while the rom is being cleared
	a_no_done_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("response during rom clear");

	// every transfer gives a response after the input, decode and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("response missing after transfer");

	// io fields stay zero unless forwarded
	a_io_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_IO) |-> (rsp.io_window_off == '0 && !rsp.io_is_write))
		else $error("io fields set on non-io response");

	// failed accesses return no data
	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (rsp.status == ST_MISALIGN || rsp.status == ST_FAULT))
		|-> rsp.read_data == '0)
		else $error("data on failed access");

	// clear sweep ends only after the last rom word
	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(clr_idx_q) == {RA{1'b1}})
		else $error("rom clear ended early");

endmodule
`default_nettype wire

FILE: src/pmad_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmad_ram
// Generic simple dual-port RAM: one write port with byte enables, one read
// port with registered read data.
// ----------------------------------------------------------------------------
module pmad_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [WIDTH/8-1:0]       be,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	localparam int LANES = WIDTH / 8;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// byte-lane write
	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			if (we && be[i]) begin
				mem_q[waddr][i*8 +: 8] <= wdata[i*8 +: 8];
			end
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire
